>>> sv/udp_hb_pkg.sv
// Shared types, constants and checksum helpers for the UDP/IPv4 header builder.
package udp_hb_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 4096;
  localparam int unsigned HDR_BYTES        = 28;
  localparam int unsigned UDP_HDR_BYTES    = 8;
  localparam int unsigned PAYLOAD_LIMIT    =
      (MAX_PACKET_BYTES > HDR_BYTES) ? (MAX_PACKET_BYTES - HDR_BYTES) : 0;
  localparam int unsigned CNT_W            = $clog2(PAYLOAD_LIMIT + 1);

  localparam logic [7:0]  IP_VERSION    = 8'h45;
  localparam logic [7:0]  IP_TTL        = 8'd64;
  localparam logic [7:0]  UDP_PROTO_NUM = 8'd17;
  localparam logic [15:0] CSUM_ALL_ONE  = 16'hffff;

  // Checksum accumulation: two terms per step, six steps.
  localparam int unsigned CALC_STEPS = 6;
  localparam int unsigned STEP_W     = $clog2(CALC_STEPS);

  // Header word positions.
  localparam int unsigned WORD_COUNT = 14;
  localparam int unsigned IDX_W      = 4;
  localparam logic [IDX_W-1:0] IDX_VER_TOS   = 4'd0;
  localparam logic [IDX_W-1:0] IDX_TOT_LEN   = 4'd1;
  localparam logic [IDX_W-1:0] IDX_IDENT     = 4'd2;
  localparam logic [IDX_W-1:0] IDX_FRAG      = 4'd3;
  localparam logic [IDX_W-1:0] IDX_TTL_PROTO = 4'd4;
  localparam logic [IDX_W-1:0] IDX_IP_CSUM   = 4'd5;
  localparam logic [IDX_W-1:0] IDX_SRC_HI    = 4'd6;
  localparam logic [IDX_W-1:0] IDX_SRC_LO    = 4'd7;
  localparam logic [IDX_W-1:0] IDX_DST_HI    = 4'd8;
  localparam logic [IDX_W-1:0] IDX_DST_LO    = 4'd9;
  localparam logic [IDX_W-1:0] IDX_SPORT     = 4'd10;
  localparam logic [IDX_W-1:0] IDX_DPORT     = 4'd11;
  localparam logic [IDX_W-1:0] IDX_UDP_LEN   = 4'd12;
  localparam logic [IDX_W-1:0] IDX_UDP_CSUM  = 4'd13;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_ADDR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_ADDR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_PORT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_PORT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDENT    = 3'd4;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] ident;
  } cfg_t;

  // Per-packet summary handed from the front to the back.
  typedef struct packed {
    logic [15:0]      sum;
    logic [7:0]       held;
    logic [CNT_W-1:0] count;
    logic             ovf;
  } pkt_rec_t;

  typedef struct packed {
    logic     full;
    logic     empty;
  } q_status_t;

  // One's-complement add with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

  // Two terms into the accumulator at once.
  function automatic logic [15:0] oc_add3(input logic [15:0] acc, input logic [15:0] a,
                                          input logic [15:0] b);
    logic [17:0] s;
    logic [16:0] f;
    logic [16:0] r;
    s = {2'b0, acc} + {2'b0, a} + {2'b0, b};
    f = {1'b0, s[15:0]} + {15'd0, s[17:16]};
    r = {1'b0, f[15:0]} + {16'd0, f[16]};
    return r[15:0];
  endfunction

endpackage

>>> sv/udp_hb_front.sv
// Front end: takes payload bytes, keeps the running sum and count, queues a summary per packet.
module udp_hb_front import udp_hb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      acc_i,
  input  logic [7:0] data_byte_i,
  input  logic      byte_valid_i,
  input  logic      end_of_payload_i,
  output logic      push_o,
  output pkt_rec_t  rec_o
);

  logic [15:0]      sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       held_q, held_d;
  logic             odd_q, odd_d;
  logic             ovf_q, ovf_d;

  logic [15:0]      sum_n;
  logic [CNT_W-1:0] cnt_n;
  logic [7:0]       held_n;
  logic             odd_n;
  logic             ovf_n;

  always_comb begin
    sum_n  = sum_q;
    cnt_n  = cnt_q;
    held_n = held_q;
    odd_n  = odd_q;
    ovf_n  = ovf_q;
    if (byte_valid_i) begin
      if (cnt_q < CNT_W'(PAYLOAD_LIMIT)) begin
        if (odd_q) begin
          sum_n  = oc_add(sum_q, {held_q, data_byte_i});
          odd_n  = 1'b0;
          held_n = 8'd0;
        end else begin
          held_n = data_byte_i;
          odd_n  = 1'b1;
        end
        cnt_n = cnt_q + CNT_W'(1);
      end else begin
        // drop the byte, flag the packet
        ovf_n = 1'b1;
      end
    end
  end

  assign push_o      = acc_i & end_of_payload_i;
  assign rec_o.sum   = sum_n;
  assign rec_o.held  = held_n;
  assign rec_o.count = cnt_n;
  assign rec_o.ovf   = ovf_n;

  always_comb begin
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    held_d = held_q;
    odd_d  = odd_q;
    ovf_d  = ovf_q;
    if (acc_i) begin
      if (end_of_payload_i) begin
        sum_d  = 16'd0;
        cnt_d  = '0;
        held_d = 8'd0;
        odd_d  = 1'b0;
        ovf_d  = 1'b0;
      end else begin
        sum_d  = sum_n;
        cnt_d  = cnt_n;
        held_d = held_n;
        odd_d  = odd_n;
        ovf_d  = ovf_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= 16'd0;
      cnt_q  <= '0;
      held_q <= 8'd0;
      odd_q  <= 1'b0;
      ovf_q  <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
      held_q <= held_d;
      odd_q  <= odd_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

>>> sv/udp_hb_fifo.sv
// Short queue of packet summaries between the front and the back.
module udp_hb_fifo import udp_hb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  pkt_rec_t  din_i,
  input  logic      pop_i,
  output pkt_rec_t  dout_o,
  output q_status_t status_o
);

  pkt_rec_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QPTR_W:0]   fill_q, fill_d;
  logic              do_push;
  logic              do_pop;

  assign status_o.full  = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status_o.empty = (fill_q == '0);
  assign do_push = push_i & ~status_o.full;
  assign do_pop  = pop_i & ~status_o.empty;
  assign dout_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (do_push) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + (QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

endmodule

>>> sv/udp_hb_back.sv
// Back end: folds the checksums for one packet, then streams the 14 header words.
module udp_hb_back import udp_hb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             q_empty_i,
  input  pkt_rec_t         rec_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [15:0]      header_word_o,
  output logic [IDX_W-1:0] word_index_o,
  output logic             last_word_o,
  output logic             length_error_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e            state_q, state_d;
  pkt_rec_t          rec_q, rec_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [15:0]       ip_acc_q, ip_acc_d;
  logic [15:0]       udp_acc_q, udp_acc_d;

  logic              ov_q, ov_d;
  logic [15:0]       ow_q, ow_d;
  logic [IDX_W-1:0]  oi_q, oi_d;
  logic              ol_q, ol_d;
  logic              oe_q, oe_d;

  logic [15:0] tot_len, udp_len, ip_csum, udp_csum;
  logic [15:0] ip_a, ip_b, udp_a, udp_b;
  logic [15:0] word;
  logic        slot_free;

  assign tot_len  = 16'(HDR_BYTES) + 16'(rec_q.count);
  assign udp_len  = 16'(UDP_HDR_BYTES) + 16'(rec_q.count);
  assign ip_csum  = ~ip_acc_q;
  assign udp_csum = (udp_acc_q == CSUM_ALL_ONE) ? CSUM_ALL_ONE : ~udp_acc_q;
  assign slot_free = ~ov_q | ~out_stall_i;

  // Term pairs for each accumulation step.
  always_comb begin
    ip_a  = 16'd0;
    ip_b  = 16'd0;
    udp_a = 16'd0;
    udp_b = 16'd0;
    case (step_q)
      STEP_W'(0): begin
        ip_a  = {IP_VERSION, 8'h00};
        ip_b  = tot_len;
        udp_a = rec_q.sum;
        udp_b = {rec_q.held, 8'h00};
      end
      STEP_W'(1): begin
        ip_a  = cfg_i.ident;
        ip_b  = {IP_TTL, UDP_PROTO_NUM};
        udp_a = cfg_i.src_addr[31:16];
        udp_b = cfg_i.src_addr[15:0];
      end
      STEP_W'(2): begin
        ip_a  = cfg_i.src_addr[31:16];
        ip_b  = cfg_i.src_addr[15:0];
        udp_a = cfg_i.dst_addr[31:16];
        udp_b = cfg_i.dst_addr[15:0];
      end
      STEP_W'(3): begin
        ip_a  = cfg_i.dst_addr[31:16];
        ip_b  = cfg_i.dst_addr[15:0];
        udp_a = {8'h00, UDP_PROTO_NUM};
        udp_b = udp_len;
      end
      STEP_W'(4): begin
        udp_a = cfg_i.src_port;
        udp_b = cfg_i.dst_port;
      end
      STEP_W'(5): begin
        udp_a = udp_len;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (idx_q)
      IDX_VER_TOS:   word = {IP_VERSION, 8'h00};
      IDX_TOT_LEN:   word = tot_len;
      IDX_IDENT:     word = cfg_i.ident;
      IDX_FRAG:      word = 16'd0;
      IDX_TTL_PROTO: word = {IP_TTL, UDP_PROTO_NUM};
      IDX_IP_CSUM:   word = ip_csum;
      IDX_SRC_HI:    word = cfg_i.src_addr[31:16];
      IDX_SRC_LO:    word = cfg_i.src_addr[15:0];
      IDX_DST_HI:    word = cfg_i.dst_addr[31:16];
      IDX_DST_LO:    word = cfg_i.dst_addr[15:0];
      IDX_SPORT:     word = cfg_i.src_port;
      IDX_DPORT:     word = cfg_i.dst_port;
      IDX_UDP_LEN:   word = udp_len;
      IDX_UDP_CSUM:  word = udp_csum;
      default:       word = 16'd0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    rec_d     = rec_q;
    step_d    = step_q;
    idx_d     = idx_q;
    ip_acc_d  = ip_acc_q;
    udp_acc_d = udp_acc_q;
    ov_d      = ov_q & out_stall_i;
    ow_d      = ow_q;
    oi_d      = oi_q;
    ol_d      = ol_q;
    oe_d      = oe_q;
    pop_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o     = 1'b1;
          rec_d     = rec_i;
          step_d    = '0;
          ip_acc_d  = 16'd0;
          udp_acc_d = 16'd0;
          state_d   = ST_CALC;
        end
      end
      ST_CALC: begin
        ip_acc_d  = oc_add3(ip_acc_q, ip_a, ip_b);
        udp_acc_d = oc_add3(udp_acc_q, udp_a, udp_b);
        if (step_q == STEP_W'(CALC_STEPS - 1)) begin
          idx_d   = '0;
          state_d = ST_EMIT;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          ov_d = 1'b1;
          ow_d = word;
          oi_d = idx_q;
          ol_d = (idx_q == IDX_UDP_CSUM);
          oe_d = rec_q.ovf;
          if (idx_q == IDX_UDP_CSUM) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q     <= rec_d;
    step_q    <= step_d;
    idx_q     <= idx_d;
    ip_acc_q  <= ip_acc_d;
    udp_acc_q <= udp_acc_d;
    ow_q      <= ow_d;
    oi_q      <= oi_d;
    ol_q      <= ol_d;
    oe_q      <= oe_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o    = ov_q;
  assign header_word_o  = ow_q;
  assign word_index_o   = oi_q;
  assign last_word_o    = ol_q;
  assign length_error_o = oe_q;

endmodule

>>> sv/udp_ipv4_header_builder.sv
// Header word 0 follows the taken end-of-payload request through the summary queue, the
// back end's fetch and checksum fold, and its output register. Throughput: one payload
// byte per cycle unless stalled; all 14 words of a header go out before the next fetch.
// Input stalls only while two packet summaries wait in the queue.
// Reset (async, active low) clears sums, counts, queue, state and the config registers.
module udp_ipv4_header_builder import udp_hb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 byte_valid_i,
  input  logic                 end_of_payload_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [15:0]          header_word_o,
  output logic [IDX_W-1:0]     word_index_o,
  output logic                 last_word_o,
  output logic                 length_error_o
);

  cfg_t      cfg_q, cfg_d;
  q_status_t q_status;
  pkt_rec_t  push_rec, pop_rec;
  logic      push, pop, in_acc;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SRC_ADDR: cfg_d.src_addr = cfg_wdata_i;
        CFG_DST_ADDR: cfg_d.dst_addr = cfg_wdata_i;
        CFG_SRC_PORT: cfg_d.src_port = cfg_wdata_i[15:0];
        CFG_DST_PORT: cfg_d.dst_port = cfg_wdata_i[15:0];
        CFG_IDENT:    cfg_d.ident    = cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = q_status.full;
  assign in_acc     = in_valid_i & ~in_stall_o;

  udp_hb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .acc_i            (in_acc),
    .data_byte_i      (data_byte_i),
    .byte_valid_i     (byte_valid_i),
    .end_of_payload_i (end_of_payload_i),
    .push_o           (push),
    .rec_o            (push_rec)
  );

  udp_hb_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .din_i    (push_rec),
    .pop_i    (pop),
    .dout_o   (pop_rec),
    .status_o (q_status)
  );

  udp_hb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_empty_i      (q_status.empty),
    .rec_i          (pop_rec),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .header_word_o  (header_word_o),
    .word_index_o   (word_index_o),
    .last_word_o    (last_word_o),
    .length_error_o (length_error_o)
  );

endmodule

>>> sv/udp_hb_chk.sv
// Port-level checker for the header builder, bound to the top level.
module udp_hb_chk import udp_hb_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [15:0]      header_word_o,
  input logic [IDX_W-1:0] word_index_o,
  input logic             last_word_o
);

  // hold a stalled word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(header_word_o)
      && $stable(word_index_o))
    else $error("stalled header word changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_word_o |-> word_index_o == IDX_UDP_CSUM && header_word_o != 16'd0)
    else $error("last word is not a nonzero UDP checksum");

  // words of one header follow without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_word_o |=>
      out_valid_o && word_index_o == $past(word_index_o) + IDX_W'(1))
    else $error("header word sequence broken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && word_index_o == IDX_TTL_PROTO |-> header_word_o == {IP_TTL, UDP_PROTO_NUM})
    else $error("TTL/protocol word wrong");

endmodule

bind udp_ipv4_header_builder udp_hb_chk u_udp_hb_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .header_word_o (header_word_o),
  .word_index_o  (word_index_o),
  .last_word_o   (last_word_o)
);

>>> verif/udp_ipv4_header_builder_tb.sv
// Self-checking testbench for the UDP/IPv4 header builder: streamed payload against predicted headers.
`timescale 1ns / 100ps

module udp_ipv4_header_builder_tb import udp_hb_pkg::*;;

  localparam int unsigned CYCLE_LIMIT          = 400000;
  localparam int unsigned DRAIN_CYCLES         = 40;
  localparam int unsigned FINAL_WAIT           = 20000;
  localparam int unsigned LONG_HOLD            = 400;
  localparam int unsigned RAND_ITEMS_PER_PHASE = 54;
  localparam int unsigned MAX_PRINTED          = 200;
  localparam int          NO_CHECK             = -1;

  typedef enum logic {ROW_REQ, ROW_CFG_MAX} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [7:0]  data;
    logic        bv;
    logic        eop;
    int unsigned reps;
    logic        ramp;
    int          exp_len;
    int          exp_err;
    int          exp_csum;
  } stim_row_t;

  typedef struct packed {
    logic [15:0]      word;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             err;
  } hdr_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           data_byte_i = '0;
  logic                 byte_valid_i = 1'b0;
  logic                 end_of_payload_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [15:0]          header_word_o;
  logic [IDX_W-1:0]     word_index_o;
  logic                 last_word_o;
  logic                 length_error_o;

  udp_ipv4_header_builder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .byte_valid_i     (byte_valid_i),
    .end_of_payload_i (end_of_payload_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .header_word_o    (header_word_o),
    .word_index_o     (word_index_o),
    .last_word_o      (last_word_o),
    .length_error_o   (length_error_o)
  );

  // Predictor state: register copy and per-packet accumulation.
  cfg_t        cfg_shadow = '0;
  logic [15:0] pay_sum = '0;
  int unsigned byte_cnt = 0;
  logic [7:0]  held = '0;
  logic        odd = 1'b0;
  logic        dropped = 1'b0;

  hdr_word_t   pending_words[$];
  stim_row_t   script[$];
  int unsigned mismatches = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned hold_request = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] ones_sum16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  // Take one accepted request into the predictor; on end of payload queue 14 header words.
  task automatic model_request(input logic [7:0] b, input logic bv, input logic eop);
    logic [15:0] w [WORD_COUNT];
    logic [15:0] ip_acc;
    logic [15:0] udp_acc;
    logic [15:0] udp_len;
    hdr_word_t   entry;
    int          i;
    if (bv) begin
      if (byte_cnt < PAYLOAD_LIMIT) begin
        if (odd) begin
          pay_sum = ones_sum16(pay_sum, {held, b});
          odd = 1'b0;
          held = '0;
        end else begin
          held = b;
          odd = 1'b1;
        end
        byte_cnt++;
      end else begin
        dropped = 1'b1;
      end
    end
    if (eop) begin
      udp_len = 16'(UDP_HDR_BYTES + byte_cnt);
      w[IDX_VER_TOS]   = {IP_VERSION, 8'h00};
      w[IDX_TOT_LEN]   = 16'(HDR_BYTES + byte_cnt);
      w[IDX_IDENT]     = cfg_shadow.ident;
      w[IDX_FRAG]      = '0;
      w[IDX_TTL_PROTO] = {IP_TTL, UDP_PROTO_NUM};
      w[IDX_IP_CSUM]   = '0;
      w[IDX_SRC_HI]    = cfg_shadow.src_addr[31:16];
      w[IDX_SRC_LO]    = cfg_shadow.src_addr[15:0];
      w[IDX_DST_HI]    = cfg_shadow.dst_addr[31:16];
      w[IDX_DST_LO]    = cfg_shadow.dst_addr[15:0];
      w[IDX_SPORT]     = cfg_shadow.src_port;
      w[IDX_DPORT]     = cfg_shadow.dst_port;
      w[IDX_UDP_LEN]   = udp_len;
      w[IDX_UDP_CSUM]  = '0;
      ip_acc = '0;
      for (i = 0; i <= int'(IDX_DST_LO); i++) ip_acc = ones_sum16(ip_acc, w[i]);
      w[IDX_IP_CSUM] = ~ip_acc;
      // Pseudo-header, UDP header and payload; pad an odd tail byte with zero.
      udp_acc = pay_sum;
      if (odd) udp_acc = ones_sum16(udp_acc, {held, 8'h00});
      for (i = int'(IDX_SRC_HI); i <= int'(IDX_DPORT); i++) udp_acc = ones_sum16(udp_acc, w[i]);
      udp_acc = ones_sum16(udp_acc, {8'h00, UDP_PROTO_NUM});
      udp_acc = ones_sum16(udp_acc, udp_len);
      udp_acc = ones_sum16(udp_acc, udp_len);
      udp_acc = ~udp_acc;
      if (udp_acc == 16'h0000) udp_acc = CSUM_ALL_ONE;
      w[IDX_UDP_CSUM] = udp_acc;
      for (i = 0; i < WORD_COUNT; i++) begin
        entry.word = w[i];
        entry.idx  = IDX_W'(i);
        entry.last = (i == WORD_COUNT - 1);
        entry.err  = dropped;
        pending_words.push_back(entry);
      end
      pay_sum = '0;
      byte_cnt = 0;
      held = '0;
      odd = 1'b0;
      dropped = 1'b0;
    end
  endtask

  // Offer one request, idling first at random, and hold it until accepted.
  task automatic send_request(input logic [7:0] b, input logic bv, input logic eop);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    data_byte_i      <= b;
    byte_valid_i     <= bv;
    end_of_payload_i <= eop;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    model_request(b, bv, eop);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_SRC_ADDR: cfg_shadow.src_addr = val;
      CFG_DST_ADDR: cfg_shadow.dst_addr = val;
      CFG_SRC_PORT: cfg_shadow.src_port = val[15:0];
      CFG_DST_PORT: cfg_shadow.dst_port = val[15:0];
      CFG_IDENT:    cfg_shadow.ident    = val[15:0];
      default: ;  // unknown index: no effect
    endcase
  endtask

  task automatic write_all(input logic [31:0] src, input logic [31:0] dst,
                           input logic [31:0] sport, input logic [31:0] dport,
                           input logic [31:0] id);
    write_reg(CFG_SRC_ADDR, src);
    write_reg(CFG_DST_ADDR, dst);
    write_reg(CFG_SRC_PORT, sport);
    write_reg(CFG_DST_PORT, dport);
    write_reg(CFG_IDENT, id);
    write_reg(CFG_IDX_W'(CFG_IDENT + 1 + $urandom_range(2)), $urandom);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid, wait for every header word, then let the back end go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic void add_row(input row_kind_e kind, input logic [7:0] data,
                                  input logic bv, input logic eop, input int unsigned reps,
                                  input logic ramp, input int exp_len, input int exp_err,
                                  input int exp_csum);
    stim_row_t row;
    row.kind = kind;
    row.data = data;
    row.bv = bv;
    row.eop = eop;
    row.reps = reps;
    row.ramp = ramp;
    row.exp_len = exp_len;
    row.exp_err = exp_err;
    row.exp_csum = exp_csum;
    script.push_back(row);
  endfunction

  // Mostly well-formed packets with random bytes, some ignored requests in between.
  task automatic random_traffic(input int unsigned quota);
    int unsigned sent;
    int unsigned len;
    int unsigned n;
    logic        tail_on_end;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(99) < 10) begin
        send_request(8'($urandom), 1'b0, 1'b0);
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(120, 13) : $urandom_range(12);
        tail_on_end = (len != 0) && ($urandom_range(2) == 0);
        for (n = 0; n < len - tail_on_end; n++) begin
          if ($urandom_range(19) == 0) send_request(8'($urandom), 1'b0, 1'b0);
          send_request(8'($urandom), 1'b1, 1'b0);
          sent++;
        end
        send_request(8'($urandom), tail_on_end, 1'b1);
        sent++;
      end
    end
  endtask

  initial begin : receiver
    hdr_word_t   want;
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_words.size() == 0) begin
          report_mismatch("header word with none pending", 32'(header_word_o), 32'd0);
        end else begin
          want = pending_words.pop_front();
          if (header_word_o !== want.word)
            report_mismatch($sformatf("header_word[%0d]", want.idx), 32'(header_word_o),
                            32'(want.word));
          if (word_index_o !== want.idx)
            report_mismatch("word_index", 32'(word_index_o), 32'(want.idx));
          if (last_word_o !== want.last)
            report_mismatch("last_word", 32'(last_word_o), 32'(want.last));
          if (length_error_o !== want.err)
            report_mismatch("length_error", 32'(length_error_o), 32'(want.err));
        end
      end
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : main
    int unsigned k;
    int          base;
    int unsigned waited;
    int unsigned phase;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers at reset: all zero.
    add_row(ROW_REQ, 8'h00, 1'b0, 1'b0, 2, 1'b0, NO_CHECK, NO_CHECK, NO_CHECK);
    // Empty payload.
    add_row(ROW_REQ, 8'hff, 1'b0, 1'b1, 1, 1'b0, 28, 0, 'hffde);
    // Payload word chosen so the computed UDP checksum is zero: sent as all ones.
    add_row(ROW_REQ, 8'hff, 1'b1, 1'b0, 1, 1'b0, NO_CHECK, NO_CHECK, NO_CHECK);
    add_row(ROW_REQ, 8'hda, 1'b1, 1'b0, 1, 1'b0, NO_CHECK, NO_CHECK, NO_CHECK);
    add_row(ROW_REQ, 8'h00, 1'b0, 1'b1, 1, 1'b0, 30, 0, 'hffff);
    // Byte carried on the end request.
    add_row(ROW_REQ, 8'h00, 1'b1, 1'b0, 1, 1'b0, NO_CHECK, NO_CHECK, NO_CHECK);
    add_row(ROW_REQ, 8'hff, 1'b1, 1'b1, 1, 1'b0, 30, 0, NO_CHECK);
    // Single odd byte, padded with zero.
    add_row(ROW_REQ, 8'ha5, 1'b1, 1'b1, 1, 1'b0, 29, 0, NO_CHECK);
    // Requests without a byte inside a packet.
    add_row(ROW_REQ, 8'h12, 1'b1, 1'b0, 1, 1'b0, NO_CHECK, NO_CHECK, NO_CHECK);
    add_row(ROW_REQ, 8'h34, 1'b0, 1'b0, 1, 1'b0, NO_CHECK, NO_CHECK, NO_CHECK);
    add_row(ROW_REQ, 8'h56, 1'b1, 1'b0, 1, 1'b0, NO_CHECK, NO_CHECK, NO_CHECK);
    add_row(ROW_REQ, 8'h78, 1'b0, 1'b1, 1, 1'b0, 30, 0, NO_CHECK);
    // All registers at their maximum.
    add_row(ROW_CFG_MAX, 8'h00, 1'b0, 1'b0, 0, 1'b0, NO_CHECK, NO_CHECK, NO_CHECK);
    add_row(ROW_REQ, 8'h00, 1'b0, 1'b1, 1, 1'b0, 28, 0, NO_CHECK);
    // Over-long payload: fill to the limit, then drop the rest.
    add_row(ROW_REQ, 8'h00, 1'b1, 1'b0, PAYLOAD_LIMIT, 1'b1, NO_CHECK, NO_CHECK, NO_CHECK);
    add_row(ROW_REQ, 8'hff, 1'b1, 1'b0, 3, 1'b0, NO_CHECK, NO_CHECK, NO_CHECK);
    add_row(ROW_REQ, 8'h5a, 1'b1, 1'b1, 1, 1'b0, HDR_BYTES + PAYLOAD_LIMIT, 1, NO_CHECK);
    // Error flag clears with the next packet.
    add_row(ROW_REQ, 8'hc3, 1'b1, 1'b0, 1, 1'b0, NO_CHECK, NO_CHECK, NO_CHECK);
    add_row(ROW_REQ, 8'h3c, 1'b1, 1'b1, 1, 1'b0, 30, 0, NO_CHECK);
    // Exactly at the limit, last byte on the end request.
    add_row(ROW_REQ, 8'h80, 1'b1, 1'b0, PAYLOAD_LIMIT - 1, 1'b1, NO_CHECK, NO_CHECK, NO_CHECK);
    add_row(ROW_REQ, 8'h7e, 1'b1, 1'b1, 1, 1'b0, HDR_BYTES + PAYLOAD_LIMIT, 0, NO_CHECK);

    send_idle = 6;
    recv_idle = 51;
    foreach (script[r]) begin
      if (script[r].kind == ROW_CFG_MAX) begin
        settle();
        write_all('1, '1, '1, '1, '1);
      end else begin
        for (k = 0; k < script[r].reps; k++)
          send_request(script[r].ramp ? 8'(script[r].data + k) : script[r].data,
                       script[r].bv, script[r].eop);
        if (script[r].eop) begin
          // Pin the fields known by inspection on the header just queued.
          base = pending_words.size() - WORD_COUNT;
          if (script[r].exp_len != NO_CHECK)
            pending_words[base + IDX_TOT_LEN].word = 16'(script[r].exp_len);
          if (script[r].exp_csum != NO_CHECK)
            pending_words[base + IDX_UDP_CSUM].word = 16'(script[r].exp_csum);
          if (script[r].exp_err != NO_CHECK)
            for (k = 0; k < WORD_COUNT; k++) pending_words[base + k].err = script[r].exp_err[0];
        end
      end
    end

    for (phase = 0; phase < 3; phase++) begin
      settle();
      write_all($urandom, $urandom, $urandom, $urandom, $urandom);
      case (phase)
        0: begin
          send_idle = 6;
          recv_idle = 51;
        end
        1: begin
          send_idle = 51;
          recv_idle = 6;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          // Long receiver hold-off so the summary queue fills and the input stalls.
          hold_request = LONG_HOLD;
        end
      endcase
      random_traffic(RAND_ITEMS_PER_PHASE);
    end

    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_words.size() != 0 && waited < FINAL_WAIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_words.size() != 0)
      report_mismatch("header words never delivered", 32'(pending_words.size()), 32'd0);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/udp_hb_pkg.sv
sv/udp_hb_front.sv
sv/udp_hb_fifo.sv
sv/udp_hb_back.sv
sv/udp_ipv4_header_builder.sv
sv/udp_hb_chk.sv
verif/udp_ipv4_header_builder_tb.sv
